[rtl/core/decimal_add_sub_multiply_unit_assert.svh]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - assertion macros
// Shorthand for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH
`define DECIMAL_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH

// The expression must hold in the same cycle as the condition.
`define DASM_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// The expression must hold in the cycle after the condition.
`define DASM_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[rtl/core/dasm_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - shared package
// Command codes, stream layout constants, types and the decimal digit split.
// ----------------------------------------------------------------------------
`default_nettype none

package dasm_pkg;

   // Field and stream widths.
   localparam int DIGIT_W      = 4;
   localparam int FIELD_W      = 64;
   localparam int RES_W        = 2 * FIELD_W;
   localparam int REQ_DATA_W   = 136;
   localparam int RSP_DATA_W   = 136;
   localparam int RSP_PAD_W    = RSP_DATA_W - RES_W - 1;

   // Request layout, lowest bit first: cmd, operand_a, operand_b.
   localparam int REQ_CMD_LSB  = 0;
   localparam int REQ_A_LSB    = 2;
   localparam int REQ_B_LSB    = REQ_A_LSB + FIELD_W;

   // Response layout, lowest bit first: result_low, result_high, status.
   localparam int RSP_STATUS_BIT = RES_W;

   // Command codes.
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;

   typedef logic [DIGIT_W-1:0] digit_type;

   // One decimal step: the low digit and the carry into the next position.
   typedef struct packed {
      logic [4:0] carry;
      digit_type  digit;
   } digit_split_type;

   // Start control for the add/subtract unit.
   typedef struct packed {
      logic start;
      logic sub_mode;
   } unit_ctl_type;

   // Split a value of up to 319 into value / 10 and value % 10.
   // The quotient comes from a multiply by 205 and a shift by 11, kept to five
   // bits, which is exact for all values below 320.
   function automatic digit_split_type dec_split(input logic [8:0] value);
      logic [16:0]     scaled;
      logic [4:0]      quot;
      logic [8:0]      tens;
      digit_split_type res;
      scaled    = 17'(value) * 17'd205;
      quot      = scaled[15:11];
      tens      = 9'(quot) * 9'd10;
      res.carry = quot;
      res.digit = 4'(value - tens);
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/core/decimal_add_sub_multiply_unit.sv]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - top level
// Packed-BCD add, compare-and-subtract and schoolbook multiply on digit-serial
// datapaths, with a registered response stage.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transaction contents
//   req_     in         cmd, operand_a, operand_b
//   rsp_     out        result_low, result_high, status
//
// Add and subtract step the adder once per digit. Multiply runs MAX_DIGITS
// passes over the running partial sum, one per multiplier digit.
// One transaction is in the datapath at a time; a stalled response holds the
// datapath result. Reset is synchronous and clears the control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_add_sub_multiply_unit
   import dasm_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: cmd[1:0], operand_a[63:0], operand_b[63:0], zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: result_low[63:0], result_high[63:0], status, zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int OPW    = DIGIT_W * MAX_DIGITS;
   localparam int SUM_W  = DIGIT_W * (MAX_DIGITS + 1);
   localparam int PROD_W = 2 * OPW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [1:0]            req_cmd;
   logic [FIELD_W-1:0]    req_a;
   logic [FIELD_W-1:0]    req_b;
   unit_ctl_type          add_ctl;
   logic                  mul_start;
   logic [SUM_W-1:0]      sum_digits;
   logic                  not_below;
   logic                  add_done;
   logic [PROD_W-1:0]     product;
   logic                  mul_done;
   logic [RES_W-1:0]      res_val;
   logic                  status_val;
   logic                  load_rsp;

   // Request fields and unit starts.
   assign req_cmd    = req_tdata[REQ_CMD_LSB +: 2];
   assign req_a      = req_tdata[REQ_A_LSB +: FIELD_W];
   assign req_b      = req_tdata[REQ_B_LSB +: FIELD_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign add_ctl.start    = accept && ((req_cmd == CMD_ADD) || (req_cmd == CMD_SUB));
   assign add_ctl.sub_mode = (req_cmd == CMD_SUB);
   assign mul_start        = accept && (req_cmd == CMD_MUL);

   dasm_addsub #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_addsub (
      .clock      (clock),
      .reset      (reset),
      .ctl        (add_ctl),
      .operand_a  (req_a[OPW-1:0]),
      .operand_b  (req_b[OPW-1:0]),
      .sum_digits (sum_digits),
      .not_below  (not_below),
      .done       (add_done)
   );

   dasm_mul #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand_a (req_a[OPW-1:0]),
      .operand_b (req_b[OPW-1:0]),
      .product   (product),
      .done      (mul_done)
   );

   // Result formatting by command; a refused subtract reads as zero.
   always_comb begin
      res_val    = '0;
      status_val = 1'b0;
      case (cmd_ff)
         CMD_ADD: begin
            res_val[SUM_W-1:0] = sum_digits;
         end
         CMD_SUB: begin
            if (not_below) begin
               res_val[OPW-1:0] = sum_digits[OPW-1:0];
            end else begin
               status_val = 1'b1;
            end
         end
         CMD_MUL: begin
            res_val[PROD_W-1:0] = product;
         end
         default: begin
            res_val = '0;
         end
      endcase
   end

   // Control state machine.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               if ((req_cmd == CMD_ADD) || (req_cmd == CMD_SUB) || (req_cmd == CMD_MUL)) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_RUN: begin
            if (add_done || mul_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads when empty or being drained in the same cycle.
   always_comb begin
      load_rsp     = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, status_val, res_val};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/dasm_addsub.sv]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - digit-serial adder/subtractor
// Walks both operands one BCD digit per cycle from the low end, forming the
// sum with a decimal carry or the difference with a borrow, and tracks the
// magnitude compare of the two operands in the same pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dasm_addsub
   import dasm_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  unit_ctl_type                        ctl,
   input  logic [DIGIT_W*MAX_DIGITS-1:0]       operand_a,
   input  logic [DIGIT_W*MAX_DIGITS-1:0]       operand_b,
   output logic [DIGIT_W*(MAX_DIGITS+1)-1:0]   sum_digits,
   output logic                                not_below,
   output logic                                done
);

   localparam int                OPW   = DIGIT_W * MAX_DIGITS;
   localparam int                CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0]  LAST  = CNT_W'(MAX_DIGITS - 1);

   logic [OPW-1:0]   a_ff, a_in;
   logic [OPW-1:0]   b_ff, b_in;
   logic [OPW-1:0]   res_ff, res_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       carry_ff, carry_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sub_ff, sub_in;
   logic             ge_ff, ge_in;

   digit_type        da;
   digit_type        db;
   digit_type        digit;
   logic [5:0]       add_sum;
   logic [5:0]       sub_diff;
   logic [5:0]       sub_wrap;
   digit_split_type  split;

   // Digit datapath for the current position.
   always_comb begin
      da       = a_ff[DIGIT_W-1:0];
      db       = b_ff[DIGIT_W-1:0];
      add_sum  = 6'(da) + 6'(db) + 6'(carry_ff);
      split    = dec_split(9'(add_sum));
      sub_diff = 6'(da) - 6'(db) - 6'(carry_ff[0]);
      sub_wrap = sub_diff + 6'd10;
      if (sub_ff) begin
         digit = sub_diff[5] ? sub_wrap[DIGIT_W-1:0] : sub_diff[DIGIT_W-1:0];
      end else begin
         digit = split.digit;
      end
   end

   // Sequencing: load on start, then one digit per cycle until the top one.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      carry_in = carry_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sub_in   = sub_ff;
      ge_in    = ge_ff;
      if (ctl.start) begin
         a_in     = operand_a;
         b_in     = operand_b;
         cnt_in   = '0;
         carry_in = '0;
         busy_in  = 1'b1;
         sub_in   = ctl.sub_mode;
         ge_in    = 1'b1;
      end else if (busy_ff) begin
         a_in   = a_ff >> DIGIT_W;
         b_in   = b_ff >> DIGIT_W;
         res_in = (res_ff >> DIGIT_W) | (OPW'(digit) << (OPW - DIGIT_W));
         // The highest differing digit decides the compare.
         if (da > db) begin
            ge_in = 1'b1;
         end else if (da < db) begin
            ge_in = 1'b0;
         end
         if (sub_ff) begin
            carry_in = {1'b0, sub_diff[5]};
         end else begin
            carry_in = split.carry[1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      cnt_ff   <= cnt_in;
      carry_ff <= carry_in;
      sub_ff   <= sub_in;
      ge_ff    <= ge_in;
   end

   assign sum_digits = {DIGIT_W'(carry_ff), res_ff};
   assign not_below  = ge_ff;
   assign done       = done_ff;

endmodule

`default_nettype wire

[rtl/core/dasm_mul.sv]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - digit-serial multiplier
// Schoolbook multiply: for each multiplier digit, one pass over the running
// partial sum adds multiplicand times that digit, one digit per cycle with a
// decimal carry. The lowest digit of each pass is final and retires into the
// low half of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module dasm_mul
   import dasm_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DIGIT_W*MAX_DIGITS-1:0]   operand_a,
   input  logic [DIGIT_W*MAX_DIGITS-1:0]   operand_b,
   output logic [2*DIGIT_W*MAX_DIGITS-1:0] product,
   output logic                            done
);

   localparam int                OPW      = DIGIT_W * MAX_DIGITS;
   localparam int                PW       = DIGIT_W * (MAX_DIGITS + 1);
   localparam int                ROW_W    = $clog2(MAX_DIGITS + 1);
   localparam int                COL_W    = $clog2(MAX_DIGITS + 3);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(MAX_DIGITS - 1);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(MAX_DIGITS + 1);
   localparam logic [COL_W-1:0]  B_END    = COL_W'(MAX_DIGITS);

   logic [OPW-1:0]   a_ff, a_in;
   logic [OPW-1:0]   b_ff, b_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [OPW-1:0]   lo_ff, lo_in;
   logic [4:0]       carry_ff, carry_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   digit_type        p_dig;
   digit_type        b_dig;
   logic [7:0]       prod;
   logic [8:0]       total;
   digit_split_type  split;

   // One multiply-accumulate step: partial digit + b digit * a digit + carry.
   always_comb begin
      p_dig = (col_ff <= B_END) ? p_ff[DIGIT_W-1:0] : '0;
      b_dig = (col_ff <  B_END) ? b_ff[DIGIT_W-1:0] : '0;
      prod  = 8'(b_dig) * 8'(a_ff[DIGIT_W-1:0]);
      total = 9'(p_dig) + 9'(prod) + 9'(carry_ff);
      split = dec_split(total);
   end

   // Pass and row sequencing.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      carry_in = carry_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = operand_a;
         b_in     = operand_b;
         p_in     = '0;
         carry_in = '0;
         row_in   = '0;
         col_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // Partial sum shifts down one digit per cycle; the new digit enters
         // at the top, so after a pass the sum sits one digit lower.
         p_in     = (p_ff >> DIGIT_W) | (PW'(split.digit) << (PW - DIGIT_W));
         carry_in = split.carry;
         col_in   = col_ff + 1'b1;
         if (col_ff == '0) begin
            lo_in = (lo_ff >> DIGIT_W) | (OPW'(split.digit) << (OPW - DIGIT_W));
         end
         if (col_ff < B_END) begin
            b_in = (b_ff >> DIGIT_W) | (OPW'(b_ff[DIGIT_W-1:0]) << (OPW - DIGIT_W));
         end
         if (col_ff == LAST_COL) begin
            col_in   = '0;
            carry_in = '0;
            a_in     = a_ff >> DIGIT_W;
            row_in   = row_ff + 1'b1;
            if (row_ff == LAST_ROW) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      lo_ff    <= lo_in;
      carry_ff <= carry_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
   end

   assign product = {p_ff[OPW-1:0], lo_ff};
   assign done    = done_ff;

endmodule

`default_nettype wire

[rtl/core/dasm_checker.sv]
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - port checker
// Watches the top level's stream ports and flags response and handshake
// behavior that the unit must never show.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_add_sub_multiply_unit_assert.svh"

module dasm_checker
   import dasm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its transaction.
   `DASM_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata),
      "response changed while stalled")

   // Only one transaction is worked on at a time.
   `DASM_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_tvalid && req_tready,
      !req_tready,
      "request accepted while busy")

   // A refused subtract carries an all-zero result.
   `DASM_ASSERT_SAME(a_refused_zero, clock, reset,
      rsp_tvalid && rsp_tdata[RSP_STATUS_BIT],
      rsp_tdata[RES_W-1:0] == '0,
      "refused result not zero")

   // The fill above the status bit is always zero.
   `DASM_ASSERT_SAME(a_pad_zero, clock, reset,
      rsp_tvalid,
      rsp_tdata[RSP_DATA_W-1:RSP_STATUS_BIT+1] == '0,
      "response fill bits not zero")

endmodule

bind decimal_add_sub_multiply_unit dasm_checker u_dasm_checker (.*);

`default_nettype wire

[dv/decimal_add_sub_multiply_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal add/subtract/multiply unit - testbench
// Drives packed-BCD add, subtract and multiply transactions into the request
// stream and checks every response against a digit-level predictor kept in
// a small scoreboard. It starts with a directed set of corner cases. Random
// transactions follow in phases with no idling, with an idle sender, with a
// stalling receiver and with both, plus one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb
   import dasm_pkg::*;
;

   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam logic [63:0] ALL_NINES       = 64'h9999_9999_9999_9999;
   localparam logic [63:0] ALL_ONES        = 64'hffff_ffff_ffff_ffff;
   localparam int          RANDOM_PER_PHASE = 308;
   localparam int          HOLD_OFF_CYCLES  = 1500;
   localparam int          HOLD_OFF_AFTER   = 60;
   localparam int          TAIL_CYCLES      = 400;

   // Predicts each response from the accepted request and checks it.
   class bcd_scoreboard;
      typedef struct {
         int          txn;
         logic [1:0]  cmd;
         logic [63:0] res_low;
         logic [63:0] res_high;
         logic        refused;
      } bcd_result_type;

      bcd_result_type pending_results[$];
      int             n_requests;
      int             n_responses;
      int             n_mismatches;
      int             n_add;
      int             n_sub;
      int             n_refused;
      int             n_mul;
      int             n_unused;

      // Digit-serial add, compare-and-subtract and schoolbook multiply.
      function bcd_result_type decimal_result(logic [1:0] cmd, logic [63:0] a,
                                              logic [63:0] b);
         int unsigned    da[16];
         int unsigned    db[16];
         int unsigned    r[32];
         int unsigned    rows[16][17];
         int unsigned    carry;
         int unsigned    sum;
         int             diff;
         int             borrow;
         int             idx;
         bit             a_not_below;
         bit             decided;
         bcd_result_type res;
         for (int i = 0; i < 32; i++) r[i] = 0;
         for (int i = 0; i < 16; i++) begin
            da[i] = a[4*i +: 4];
            db[i] = b[4*i +: 4];
         end
         res.cmd     = cmd;
         res.refused = 1'b0;
         case (cmd)
            CMD_ADD: begin
               carry = 0;
               for (int i = 0; i < 16; i++) begin
                  sum   = da[i] + db[i] + carry;
                  r[i]  = sum % 10;
                  carry = sum / 10;
               end
               r[16] = carry;
            end
            CMD_SUB: begin
               // The top differing digit decides whether the minuend is below.
               a_not_below = 1'b1;
               decided     = 1'b0;
               for (int i = 15; i >= 0; i--) begin
                  if (!decided && da[i] != db[i]) begin
                     a_not_below = da[i] > db[i];
                     decided     = 1'b1;
                  end
               end
               if (a_not_below) begin
                  borrow = 0;
                  for (int i = 0; i < 16; i++) begin
                     diff = int'(da[i]) - int'(db[i]) - borrow;
                     if (diff < 0) begin
                        diff   = diff + 10;
                        borrow = 1;
                     end else begin
                        borrow = 0;
                     end
                     r[i] = diff & 15;
                  end
               end else begin
                  res.refused = 1'b1;
               end
            end
            CMD_MUL: begin
               // One partial row per multiplier digit, top carry kept whole.
               for (int row = 0; row < 16; row++) begin
                  carry = 0;
                  for (int col = 0; col < 16; col++) begin
                     sum           = db[col] * da[row] + carry;
                     rows[row][col] = sum % 10;
                     carry         = sum / 10;
                  end
                  rows[row][16] = carry;
               end
               carry = 0;
               for (int col = 0; col < 32; col++) begin
                  sum = carry;
                  for (int row = 0; row < 16; row++) begin
                     idx = col - row;
                     if (idx >= 0 && idx <= 16) sum += rows[row][idx];
                  end
                  r[col] = sum % 10;
                  carry  = sum / 10;
               end
            end
            default: begin
            end
         endcase
         for (int i = 0; i < 16; i++) begin
            res.res_low[4*i +: 4]  = 4'(r[i]);
            res.res_high[4*i +: 4] = 4'(r[i + 16]);
         end
         return res;
      endfunction

      function void note_request(logic [1:0] cmd, logic [63:0] a, logic [63:0] b);
         bcd_result_type res;
         res     = decimal_result(cmd, a, b);
         res.txn = n_requests;
         n_requests++;
         case (cmd)
            CMD_ADD: n_add++;
            CMD_SUB: n_sub++;
            CMD_MUL: n_mul++;
            default: n_unused++;
         endcase
         if (res.refused) n_refused++;
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         n_mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         bcd_result_type got;
         bcd_result_type want;
         got.res_low  = data[FIELD_W-1:0];
         got.res_high = data[RES_W-1:FIELD_W];
         got.refused  = data[RSP_STATUS_BIT];
         n_responses++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response %h_%h with no request outstanding",
                                      got.res_high, got.res_low));
            return;
         end
         want = pending_results.pop_front();
         if (got.res_low !== want.res_low)
            report_mismatch($sformatf("txn %0d cmd %0d result_low %h, expected %h",
                                      want.txn, want.cmd, got.res_low, want.res_low));
         if (got.res_high !== want.res_high)
            report_mismatch($sformatf("txn %0d cmd %0d result_high %h, expected %h",
                                      want.txn, want.cmd, got.res_high, want.res_high));
         if (got.refused !== want.refused)
            report_mismatch($sformatf("txn %0d cmd %0d status %b, expected %b",
                                      want.txn, want.cmd, got.refused, want.refused));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bcd_scoreboard sb;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   decimal_add_sub_multiply_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Offer one request, idling first at the current rate, and wait for it.
   task automatic send_request(input logic [1:0] cmd, input logic [63:0] a,
                               input logic [63:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({b, a, cmd});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, a, b);
   endtask

   // Stop offering and let every outstanding response come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly valid BCD of random length, sometimes all nines or raw bits.
   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      int          kind;
      int          ndig;
      kind = $urandom_range(0, 99);
      if (kind < 12) return {$urandom, $urandom};
      ndig = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 16);
      v    = '0;
      for (int i = 0; i < ndig; i++)
         v[4*i +: 4] = (kind < 17) ? 4'd9 : 4'($urandom_range(0, 9));
      return v;
   endfunction

   task automatic send_random_item();
      logic [1:0]  cmd;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] swap;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 31) cmd = CMD_ADD;
      else if (pick < 62) cmd = CMD_SUB;
      else if (pick < 96) cmd = CMD_MUL;
      else cmd = CMD_UNUSED;
      a = random_operand();
      b = random_operand();
      // Most subtracts are ordered so the difference path gets exercised.
      if (cmd == CMD_SUB) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            b = a;
         end else if (pick < 80 && a < b) begin
            swap = a;
            a    = b;
            b    = swap;
         end
      end
      send_request(cmd, a, b);
   endtask

   task automatic send_directed();
      send_request(CMD_ADD, '0, '0);
      send_request(CMD_ADD, ALL_NINES, ALL_NINES);
      send_request(CMD_ADD, ALL_NINES, 64'h1);
      send_request(CMD_ADD, ALL_ONES, ALL_ONES);
      send_request(CMD_ADD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(CMD_ADD, ALL_ONES, '0);
      send_request(CMD_SUB, 64'h1234_5678_9012_3456, 64'h1234_5678_9012_3456);
      send_request(CMD_SUB, '0, '0);
      send_request(CMD_SUB, 64'h1000_0000_0000_0000, 64'h1);
      send_request(CMD_SUB, 64'h1, 64'h2);
      send_request(CMD_SUB, 64'h0999_9999_9999_9999, 64'h1000_0000_0000_0000);
      send_request(CMD_SUB, ALL_ONES, ALL_NINES);
      send_request(CMD_SUB, 64'h10, 64'h0f);
      send_request(CMD_SUB, ALL_ONES, ALL_ONES);
      send_request(CMD_SUB, 64'h0a, 64'h0f);
      send_request(CMD_MUL, '0, ALL_NINES);
      send_request(CMD_MUL, ALL_NINES, ALL_NINES);
      send_request(CMD_MUL, 64'h1, ALL_NINES);
      send_request(CMD_MUL, 64'h9000_0000_0000_0000, 64'h9000_0000_0000_0000);
      send_request(CMD_MUL, ALL_ONES, ALL_ONES);
      send_request(CMD_MUL, 64'h1234_5678, 64'h8765_4321);
      send_request(CMD_UNUSED, 64'h1234_5678_9012_3456, ALL_NINES);
      send_request(CMD_UNUSED, ALL_ONES, ALL_ONES);
   endtask

   // Response side: check each accepted transaction, then pick next tready.
   // One long hold-off lets the block fill up and stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (!hold_done && sb.n_responses >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Main sequence: reset, directed cases, then four random phases.
   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      idle_by_phase  = '{0, 53, 0, 10};
      stall_by_phase = '{0, 0, 53, 10};
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sb             = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      wait_drained();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_by_phase[phase];
         recv_stall_pct = stall_by_phase[phase];
         repeat (RANDOM_PER_PHASE) send_random_item();
         wait_drained();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d transactions: %0d add, %0d subtract (%0d refused),",
               sb.n_requests, sb.n_add, sb.n_sub, sb.n_refused);
      $display("%0d multiply and %0d with the unused command; %0d mismatches.",
               sb.n_mul, sb.n_unused, sb.n_mismatches);
      if (sb.n_mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses outstanding.", sb.pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[decimal_add_sub_multiply_unit.f]
+incdir+rtl/core
rtl/core/dasm_pkg.sv
rtl/core/dasm_addsub.sv
rtl/core/dasm_mul.sv
rtl/core/decimal_add_sub_multiply_unit.sv
rtl/core/dasm_checker.sv
dv/decimal_add_sub_multiply_unit_tb.sv
